// ----- rtl/scf_pkg.sv -----
// Shared types, field widths and the accept filter for the collision filter.
// No dependencies; used by every file of the block.
package scf_pkg;

	localparam int POS_W     = 16;
	localparam int DIM_W     = 15;
	localparam int NUM_W     = 4;
	localparam int MASK_W    = 16;
	localparam int OUT_SLOTS = 16;

	// One collider as it is held in a ring cell.
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [DIM_W-1:0]        w;
		logic [DIM_W-1:0]        h;
		logic [DIM_W-1:0]        r;
		logic                    circ;
		logic [NUM_W-1:0]        layer;
		logic [NUM_W-1:0]        tag;
		logic [MASK_W-1:0]       acc_l;
		logic [MASK_W-1:0]       acc_t;
	} entry_t;

	// Outcome of one pair test, leaving the compare pipeline.
	typedef struct packed {
		logic valid;
		logic hit;
		logic mine;
		logic theirs;
	} cmp_res_t;

	// All ones accepts everything; otherwise the number must be in range and its bit set.
	function automatic logic accepts(input logic [MASK_W-1:0] mask, input logic [NUM_W-1:0] n,
			input int limit);
		return (mask == {MASK_W{1'b1}}) || ((int'(n) < limit) && mask[n]);
	endfunction

endpackage

// ----- rtl/shape_collision_filter_core.sv -----
// Top level of the collision filter: ring of collider cells plus pair tester.
// Depends on scf_pkg, scf_cell and scf_cmp.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   input   | in        | in_valid / in_ready | first, pos_x, pos_y, box_width,
//           |           |                     | box_height, radius, is_circle, layer,
//           |           |                     | tag, accepts_layers, accepts_tags
//   result  | out       | out_valid/out_ready | slot, hits_mask, hit_by_mask, overflow
//
// Sequencing: an accepted item makes one full turn of the cell ring, feeding the
//   three-stage pair tester, then a done step; an overflow item goes straight to the
//   done step. No new item is accepted until the block is idle again.
// Reset: clears the fill count, the sequencer and the result valid; cell contents
//   are left as they are and only cells below the fill count are ever used.
// Stalls: a held result only keeps the next item waiting in its done step.
module shape_collision_filter_core #(
	parameter int MAX_COLLIDERS = 16,
	parameter int NUM_LAYERS    = 16,
	parameter int NUM_TAGS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        first,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [14:0] box_width,
	input  logic [14:0] box_height,
	input  logic [14:0] radius,
	input  logic        is_circle,
	input  logic [3:0]  layer,
	input  logic [3:0]  tag,
	input  logic [15:0] accepts_layers,
	input  logic [15:0] accepts_tags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  slot,
	output logic [15:0] hits_mask,
	output logic [15:0] hit_by_mask,
	output logic        overflow
);

	localparam int IW  = $clog2(MAX_COLLIDERS);
	localparam int CW  = $clog2(MAX_COLLIDERS + 1);
	localparam int STW = $clog2(MAX_COLLIDERS + 3);
	localparam logic [STW-1:0] STEP_FEED = STW'(MAX_COLLIDERS);
	localparam logic [STW-1:0] STEP_LAST = STW'(MAX_COLLIDERS + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]     state_q;
	logic [STW-1:0] step_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q;
	scf_pkg::entry_t query_q;
	logic [15:0]    hits_q, hitby_q;

	logic [3:0]     slot_q;
	logic [15:0]    hits_out_q, hitby_out_q;
	logic           ovf_out_q;
	logic           out_valid_q;

	scf_pkg::entry_t   in_entry;
	scf_pkg::entry_t   cell_q [MAX_COLLIDERS];
	scf_pkg::cmp_res_t res;
	logic [IW-1:0]     res_idx;

	logic           accept, feeding, shift, feed_valid, finish;
	logic [CW-1:0]  eff_count;

	always_comb begin
		in_entry.x     = pos_x;
		in_entry.y     = pos_y;
		in_entry.w     = box_width;
		in_entry.h     = box_height;
		in_entry.r     = radius;
		in_entry.circ  = is_circle;
		in_entry.layer = layer;
		in_entry.tag   = tag;
		in_entry.acc_l = accepts_layers;
		in_entry.acc_t = accepts_tags;
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign eff_count  = first ? '0 : count_q;
	assign feeding    = (state_q == ST_RUN) && (step_q < STEP_FEED);
	assign shift      = feeding;
	// the ring holds slot step_q in cell 0 while feeding; only filled slots count
	assign feed_valid = feeding && (step_q < STW'(count_q));
	assign finish     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// ring of cells: each takes its upper neighbour's collider, cell 0 feeds the tester.
	// After a full turn the ring is aligned again and cell i holds slot i.
	for (genvar i = 0; i < MAX_COLLIDERS; i++) begin : g_cell
		scf_cell u_cell (
			.clk       (clk),
			.shift     (shift),
			.load      (finish && !ovf_q && (count_q == CW'(i))),
			.from_next (cell_q[(i + 1) % MAX_COLLIDERS]),
			.new_entry (query_q),
			.entry     (cell_q[i])
		);
	end

	scf_cmp #(
		.IW         (IW),
		.NUM_LAYERS (NUM_LAYERS),
		.NUM_TAGS   (NUM_TAGS)
	) u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feed_valid),
		.in_idx   (step_q[IW-1:0]),
		.stored   (cell_q[0]),
		.query    (query_q),
		.res      (res),
		.res_idx  (res_idx)
	);

	// item payload: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= in_entry;
		end
	end

	// sequencer, fill count and mask accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			hits_q  <= '0;
			hitby_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= eff_count;
						ovf_q   <= (eff_count >= CW'(MAX_COLLIDERS));
						step_q  <= '0;
						hits_q  <= '0;
						hitby_q <= '0;
						state_q <= (eff_count >= CW'(MAX_COLLIDERS)) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					// slots above fifteen have no mask bit
					if (res.valid && res.hit && (int'(res_idx) < scf_pkg::OUT_SLOTS)) begin
						if (res.mine) hits_q[4'(res_idx)] <= 1'b1;
						if (res.theirs) hitby_q[4'(res_idx)] <= 1'b1;
					end
					if (step_q == STEP_LAST) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (finish) begin
						if (!ovf_q) count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			slot_q      <= ovf_q ? 4'd0 : 4'(count_q);
			hits_out_q  <= ovf_q ? 16'd0 : hits_q;
			hitby_out_q <= ovf_q ? 16'd0 : hitby_q;
			ovf_out_q   <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot        = slot_q;
	assign hits_mask   = hits_out_q;
	assign hit_by_mask = hitby_out_q;
	assign overflow    = ovf_out_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_COLLIDERS))
		else $error("fill count beyond store depth");

	a_res_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_RUN))
		else $error("pair result outside a ring turn");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (hits_mask == 16'd0 && hit_by_mask == 16'd0 && slot == 4'd0))
		else $error("overflow result with non-zero fields");

	a_rise_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the done step");

endmodule

// ----- rtl/scf_cell.sv -----
// One cell of the collider ring: holds one stored collider.
// Depends on scf_pkg.
module scf_cell (
	input  logic           clk,
	input  logic           shift,
	input  logic           load,
	input  scf_pkg::entry_t from_next,
	input  scf_pkg::entry_t new_entry,
	output scf_pkg::entry_t entry
);

	scf_pkg::entry_t entry_q;

	// Payload only: contents are undefined until written.
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= new_entry;
		end else if (shift) begin
			entry_q <= from_next;
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/scf_cmp.sv -----
// Three-stage pair tester: filter, box/box overlap, clamped squared distance.
// Depends on scf_pkg.
module scf_cmp #(
	parameter int IW         = 4,
	parameter int NUM_LAYERS = 16,
	parameter int NUM_TAGS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [IW-1:0]    in_idx,
	input  scf_pkg::entry_t  stored,
	input  scf_pkg::entry_t  query,
	output scf_pkg::cmp_res_t res,
	output logic [IW-1:0]    res_idx
);

	// stage 1: filters, box ends, pick circle and partner
	logic signed [17:0] o_x, o_y, n_x, n_y, o_xe, o_ye, n_xe, n_ye;
	logic               both_box, both_circ, bb_hit, mine, theirs;
	logic signed [17:0] c_x, c_y, p_x, p_y, p_xe, p_ye;
	logic [15:0]        thr;

	always_comb begin
		o_x  = 18'(stored.x);
		o_y  = 18'(stored.y);
		n_x  = 18'(query.x);
		n_y  = 18'(query.y);
		o_xe = o_x + 18'(stored.w);
		o_ye = o_y + 18'(stored.h);
		n_xe = n_x + 18'(query.w);
		n_ye = n_y + 18'(query.h);
		both_box  = !stored.circ && !query.circ;
		both_circ = stored.circ && query.circ;
		bb_hit = (o_x < n_xe) && (o_xe > n_x) && (o_y < n_ye) && (o_ye > n_y);
		mine   = scf_pkg::accepts(query.acc_l, stored.layer, NUM_LAYERS) &&
			scf_pkg::accepts(query.acc_t, stored.tag, NUM_TAGS);
		theirs = scf_pkg::accepts(stored.acc_l, query.layer, NUM_LAYERS) &&
			scf_pkg::accepts(stored.acc_t, query.tag, NUM_TAGS);
		// circle is the query when it is one, else the stored entry
		if (query.circ) begin
			c_x = n_x;  c_y = n_y;
			p_x = o_x;  p_y = o_y;  p_xe = o_xe;  p_ye = o_ye;
		end else begin
			c_x = o_x;  c_y = o_y;
			p_x = n_x;  p_y = n_y;  p_xe = n_xe;  p_ye = n_ye;
		end
		if (both_circ) begin
			thr = 16'(stored.r) + 16'(query.r);
		end else begin
			thr = query.circ ? 16'(query.r) : 16'(stored.r);
		end
	end

	logic               v_s1, v_s2, v_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	logic               bb_s1, bbhit_s1, cc_s1, mine_s1, theirs_s1;
	logic signed [17:0] cx_s1, cy_s1, px_s1, py_s1, pxe_s1, pye_s1;
	logic [15:0]        thr_s1;

	always_ff @(posedge clk) begin
		idx_s1    <= in_idx;
		bb_s1     <= both_box;
		bbhit_s1  <= bb_hit;
		cc_s1     <= both_circ;
		mine_s1   <= mine;
		theirs_s1 <= theirs;
		cx_s1     <= c_x;
		cy_s1     <= c_y;
		px_s1     <= p_x;
		py_s1     <= p_y;
		pxe_s1    <= p_xe;
		pye_s1    <= p_ye;
		thr_s1    <= thr;
	end

	// stage 2: clamp to the box (or take the other centre), absolute distance
	logic signed [17:0] near_x, near_y, dx, dy, ax, ay;

	always_comb begin
		if (cc_s1) begin
			near_x = px_s1;
			near_y = py_s1;
		end else begin
			near_x = (cx_s1 < px_s1) ? px_s1 : ((cx_s1 > pxe_s1) ? pxe_s1 : cx_s1);
			near_y = (cy_s1 < py_s1) ? py_s1 : ((cy_s1 > pye_s1) ? pye_s1 : cy_s1);
		end
		dx = cx_s1 - near_x;
		dy = cy_s1 - near_y;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
	end

	logic        bb_s2, bbhit_s2, mine_s2, theirs_s2;
	logic [15:0] adx_s2, ady_s2, thr_s2;

	always_ff @(posedge clk) begin
		idx_s2    <= idx_s1;
		bb_s2     <= bb_s1;
		bbhit_s2  <= bbhit_s1;
		mine_s2   <= mine_s1;
		theirs_s2 <= theirs_s1;
		adx_s2    <= ax[15:0];
		ady_s2    <= ay[15:0];
		thr_s2    <= thr_s1;
	end

	// stage 3: squares
	logic        bb_s3, bbhit_s3, mine_s3, theirs_s3;
	logic [31:0] dxx_s3, dyy_s3, thr2_s3;

	always_ff @(posedge clk) begin
		idx_s3    <= idx_s2;
		bb_s3     <= bb_s2;
		bbhit_s3  <= bbhit_s2;
		mine_s3   <= mine_s2;
		theirs_s3 <= theirs_s2;
		dxx_s3    <= 32'(adx_s2) * 32'(adx_s2);
		dyy_s3    <= 32'(ady_s2) * 32'(ady_s2);
		thr2_s3   <= 32'(thr_s2) * 32'(thr_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		res.valid  = v_s3;
		res.mine   = mine_s3;
		res.theirs = theirs_s3;
		res.hit    = bb_s3 ? bbhit_s3 : ((33'(dxx_s3) + 33'(dyy_s3)) < 33'(thr2_s3));
	end

	assign res_idx = idx_s3;

endmodule
